### rtl/rgb_gradient_edge_threshold_macros.svh
// ----------------------------------------------------------------------------
// rgb gradient edge threshold assertion macros
// Concurrent assertion helpers shared by the rtl files; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef RGB_GRADIENT_EDGE_THRESHOLD_MACROS_SVH
`define RGB_GRADIENT_EDGE_THRESHOLD_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every edge out of reset
`define RGBE_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rgbe assertion failed");
// consequent holds in the cycle after the antecedent
`define RGBE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbe assertion failed");
`else
`define RGBE_ASSERT(name, clk, rst_n, prop)
`define RGBE_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

### rtl/rgbe_pkg.sv
// ----------------------------------------------------------------------------
// rgbe_pkg
// Shared types, constants and channel compare helpers for the edge detector.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbe_pkg;

    localparam int CHAN_W     = 8;
    localparam int COORD_W    = 10;
    localparam int THR_W      = 9;
    localparam int DIM_CFG_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int MIN_DIM    = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam logic [THR_W-1:0]     THRESHOLD_RESET = 9'd20;
    localparam logic [DIM_CFG_W-1:0] DIM_RESET       = 11'd500;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_start;
    } pixel_beat_t;

    typedef struct packed {
        logic               edge_res;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
    } result_beat_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    // work item handed from the front end to the back end
    typedef struct packed {
        rgb_t               pix;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               emit;
    } job_t;

    // twice the absolute difference against a half-unit threshold
    function automatic logic chan_exceeds(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b,
        input logic [THR_W-1:0]  thr
    );
        logic [CHAN_W-1:0] d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            return {d, 1'b0} > thr;
        end
    endfunction

    function automatic logic pair_exceeds(
        input rgb_t             a,
        input rgb_t             b,
        input logic [THR_W-1:0] thr
    );
        begin
            return chan_exceeds(a.red, b.red, thr)
                || chan_exceeds(a.green, b.green, thr)
                || chan_exceeds(a.blue, b.blue, thr);
        end
    endfunction

endpackage

`default_nettype wire

### rtl/rgbe_front.sv
// ----------------------------------------------------------------------------
// rgbe_front
// Accepts pixel beats, tracks raster position and marks interior pixels.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_gradient_edge_threshold_macros.svh"

module rgbe_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               pixel_valid,
    output logic                              pixel_ready,
    input  rgbe_pkg::pixel_beat_t             pixel,
    input  wire [rgbe_pkg::DIM_CFG_W-1:0]     image_width,
    input  wire [rgbe_pkg::DIM_CFG_W-1:0]     image_height,
    output logic                              push,
    output rgbe_pkg::job_t                    job,
    output logic [$clog2(MAX_WIDTH)-1:0]      job_addr,
    input  wire                               queue_ready
);
    import rgbe_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int BASE_W = (CW > RW) ? CW : RW;
    localparam int DW     = ((BASE_W > DIM_CFG_W) ? BASE_W : DIM_CFG_W) + 2;

    localparam logic [DW-1:0] MAX_W_D = DW'(MAX_WIDTH);
    localparam logic [DW-1:0] MAX_H_D = DW'(MAX_HEIGHT);
    localparam logic [DW-1:0] MIN_D   = DW'(MIN_DIM);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic [DW-1:0] w_raw, h_raw, w_eff, h_eff;
    logic [CW-1:0] x_cur;
    logic [RW-1:0] y_cur;
    logic [DW-1:0] xd, yd, col_inc, row_inc, row_m1;
    logic          interior, col_wrap, row_wrap, fire;

    always_comb
    begin
        w_raw = DW'(image_width);
        h_raw = DW'(image_height);
        w_eff = (w_raw < MIN_D) ? MIN_D : ((w_raw > MAX_W_D) ? MAX_W_D : w_raw);
        h_eff = (h_raw < MIN_D) ? MIN_D : ((h_raw > MAX_H_D) ? MAX_H_D : h_raw);

        // frame start puts this beat at the origin
        x_cur = pixel.frame_start ? '0 : col_reg;
        y_cur = pixel.frame_start ? '0 : row_reg;
        xd    = DW'(x_cur);
        yd    = DW'(y_cur);

        interior = (xd >= DW'(1)) && (xd + DW'(2) <= w_eff)
                && (yd >= DW'(2)) && (yd + DW'(1) <= h_eff);

        col_inc  = xd + DW'(1);
        row_inc  = yd + DW'(1);
        row_m1   = yd - DW'(1);
        col_wrap = col_inc >= w_eff;
        row_wrap = row_inc >= h_eff;

        fire        = pixel_valid && queue_ready;
        pixel_ready = queue_ready;
        push        = fire;

        job.pix.red   = pixel.red;
        job.pix.green = pixel.green;
        job.pix.blue  = pixel.blue;
        job.col       = xd[COORD_W-1:0];
        job.row       = row_m1[COORD_W-1:0];
        job.emit      = interior;
        job_addr      = x_cur;

        col_next = col_reg;
        row_next = row_reg;
        if (fire)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[RW-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
                row_next = y_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    `RGBE_ASSERT_NEXT(a_frame_start_col, clk, rst_n, fire && pixel.frame_start, col_reg == CW'(1))

endmodule

`default_nettype wire

### rtl/rgbe_queue.sv
// ----------------------------------------------------------------------------
// rgbe_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_gradient_edge_threshold_macros.svh"

module rgbe_queue #(
    parameter int AW = 10
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  rgbe_pkg::job_t   push_job,
    input  wire [AW-1:0]     push_addr,
    output logic             push_ready,
    output logic             pop_valid,
    output rgbe_pkg::job_t   pop_job,
    output logic [AW-1:0]    pop_addr,
    input  wire              pop
);
    import rgbe_pkg::*;

    localparam logic [QPTR_W:0] FULL_COUNT = (QPTR_W+1)'(QUEUE_DEPTH);

    job_t          job_store [QUEUE_DEPTH];
    logic [AW-1:0] addr_store [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    always_comb
    begin
        push_ready = count_reg != FULL_COUNT;
        pop_valid  = count_reg != '0;
        pop_job    = job_store[rd_ptr_reg];
        pop_addr   = addr_store[rd_ptr_reg];
        do_push    = push && push_ready;
        do_pop     = pop && pop_valid;

        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            job_store[wr_ptr_reg]  <= push_job;
            addr_store[wr_ptr_reg] <= push_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `RGBE_ASSERT(a_count_bound, clk, rst_n, count_reg <= FULL_COUNT)
    `RGBE_ASSERT_NEXT(a_count_step, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + (QPTR_W+1)'(1))

endmodule

`default_nettype wire

### rtl/rgbe_back.sv
// ----------------------------------------------------------------------------
// rgbe_back
// Line buffers, gradient compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_gradient_edge_threshold_macros.svh"

module rgbe_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire [rgbe_pkg::THR_W-1:0]      threshold,
    input  wire                            q_valid,
    input  rgbe_pkg::job_t                 q_job,
    input  wire [$clog2(MAX_WIDTH)-1:0]    q_addr,
    output logic                           q_pop,
    output logic                           result_valid,
    input  wire                            result_ready,
    output rgbe_pkg::result_beat_t         result
);
    import rgbe_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

    // line y-1 (partly y) and line y-2 (partly y-1), one word per column
    rgb_t line_prev_mem  [MAX_WIDTH];
    rgb_t line_prev2_mem [MAX_WIDTH];

    logic [AW-1:0] addr_p1, addr_m1;

    logic          r_valid_reg, r_valid_next;
    job_t          r_job_reg;
    logic [AW-1:0] r_addr_reg, r_addr_p1_reg, r_addr_m1_reg;
    rgb_t          rd_prev_hi_reg, rd_prev_c_reg, rd_prev2_lo_reg, rd_prev2_c_reg;

    // last line buffer write, covers the write made while this beat was read
    logic          hist_valid_reg, hist_valid_next;
    logic [AW-1:0] hist_addr_reg;
    rgb_t          hist_pix_reg, hist_prev_reg;

    logic          out_valid_reg, out_valid_next;
    result_beat_t  out_data_reg, out_data_next;

    rgb_t fwd_prev_hi, fwd_prev_c, fwd_prev2_lo, fwd_prev2_c;
    logic r_fire, edge_hit;

    always_comb
    begin
        addr_p1 = (q_addr == LAST_ADDR) ? '0 : q_addr + AW'(1);
        addr_m1 = (q_addr == '0) ? LAST_ADDR : q_addr - AW'(1);

        r_fire = r_valid_reg && (!r_job_reg.emit || !out_valid_reg || result_ready);
        q_pop  = q_valid && (!r_valid_reg || r_fire);

        fwd_prev_hi  = (hist_valid_reg && hist_addr_reg == r_addr_p1_reg)
                     ? hist_pix_reg : rd_prev_hi_reg;
        fwd_prev_c   = (hist_valid_reg && hist_addr_reg == r_addr_reg)
                     ? hist_pix_reg : rd_prev_c_reg;
        fwd_prev2_lo = (hist_valid_reg && hist_addr_reg == r_addr_m1_reg)
                     ? hist_prev_reg : rd_prev2_lo_reg;
        fwd_prev2_c  = (hist_valid_reg && hist_addr_reg == r_addr_reg)
                     ? hist_prev_reg : rd_prev2_c_reg;

        edge_hit = pair_exceeds(fwd_prev_hi, fwd_prev2_lo, threshold)
                || pair_exceeds(r_job_reg.pix, fwd_prev2_c, threshold);

        out_data_next.edge_res = edge_hit;
        out_data_next.out_col  = r_job_reg.col;
        out_data_next.out_row  = r_job_reg.row;

        if (q_pop)
        begin
            r_valid_next = 1'b1;
        end
        else if (r_fire)
        begin
            r_valid_next = 1'b0;
        end
        else
        begin
            r_valid_next = r_valid_reg;
        end

        hist_valid_next = hist_valid_reg || r_fire;

        if (r_fire && r_job_reg.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        result_valid = out_valid_reg;
        result       = out_data_reg;
    end

    // line buffer ports: two reads and one write per buffer
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_prev_hi_reg  <= line_prev_mem[addr_p1];
            rd_prev_c_reg   <= line_prev_mem[q_addr];
            rd_prev2_lo_reg <= line_prev2_mem[addr_m1];
            rd_prev2_c_reg  <= line_prev2_mem[q_addr];
        end
        if (r_fire)
        begin
            line_prev_mem[r_addr_reg]  <= r_job_reg.pix;
            line_prev2_mem[r_addr_reg] <= fwd_prev_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            r_job_reg     <= q_job;
            r_addr_reg    <= q_addr;
            r_addr_p1_reg <= addr_p1;
            r_addr_m1_reg <= addr_m1;
        end
        if (r_fire)
        begin
            hist_addr_reg <= r_addr_reg;
            hist_pix_reg  <= r_job_reg.pix;
            hist_prev_reg <= fwd_prev_c;
        end
        if (r_fire && r_job_reg.emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg    <= 1'b0;
            hist_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            r_valid_reg    <= r_valid_next;
            hist_valid_reg <= hist_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    `RGBE_ASSERT_NEXT(a_emit_lands, clk, rst_n, r_fire && r_job_reg.emit, out_valid_reg)
    `RGBE_ASSERT_NEXT(a_hist_tracks, clk, rst_n, r_fire, hist_valid_reg && hist_addr_reg == $past(r_addr_reg))
    `RGBE_ASSERT(a_no_pop_empty, clk, rst_n, !q_pop || q_valid)

endmodule

`default_nettype wire

### rtl/rgb_gradient_edge_threshold.sv
// ----------------------------------------------------------------------------
// rgb_gradient_edge_threshold
// RGB central-difference edge detector with a half-unit threshold.
// ----------------------------------------------------------------------------
// throughput: one pixel beat per cycle while the queue and result side
// accept, set by the single read stage of the dual-read line buffers
// result path: the result for pixel (x,y) is produced by pixel (x,y+1),
// via the queue, the line buffer read stage and the result register
// reset: counters, queue and pipeline valids clear, registers take their reset
// values; line buffer contents are left as they are
`default_nettype none

module rgb_gradient_edge_threshold #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              pixel_valid,
    output logic                             pixel_ready,
    input  rgbe_pkg::pixel_beat_t            pixel,
    output logic                             result_valid,
    input  wire                              result_ready,
    output rgbe_pkg::result_beat_t           result,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [rgbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [rgbe_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rgbe_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [THR_W-1:0]     thr_reg, thr_next;
    logic [DIM_CFG_W-1:0] width_reg, width_next;
    logic [DIM_CFG_W-1:0] height_reg, height_next;

    logic          push, push_ready, pop_valid, pop;
    job_t          push_job, pop_job;
    logic [AW-1:0] push_addr, pop_addr;

    always_comb
    begin
        cfg_ready   = 1'b1;
        thr_next    = thr_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESHOLD: thr_next    = cfg_data[THR_W-1:0];
                REG_WIDTH:     width_next  = cfg_data[DIM_CFG_W-1:0];
                REG_HEIGHT:    height_next = cfg_data[DIM_CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THRESHOLD_RESET;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else
        begin
            thr_reg    <= thr_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    rgbe_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .image_width  (width_reg),
        .image_height (height_reg),
        .push         (push),
        .job          (push_job),
        .job_addr     (push_addr),
        .queue_ready  (push_ready)
    );

    rgbe_queue #(
        .AW (AW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_addr  (push_addr),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop_addr   (pop_addr),
        .pop        (pop)
    );

    rgbe_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .threshold    (thr_reg),
        .q_valid      (pop_valid),
        .q_job        (pop_job),
        .q_addr       (pop_addr),
        .q_pop        (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

### verif/edge_result_checker.sv
// ----------------------------------------------------------------------------
// edge_result_checker
// Watches the pixel, result and register channels of the edge detector,
// keeps its own line buffers and pixel position, predicts the edge verdict
// for each interior pixel and compares it with the result beats in order.
// ----------------------------------------------------------------------------
module edge_result_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            pixel_valid,
    input  wire                            pixel_ready,
    input  rgbe_pkg::pixel_beat_t          pixel,
    input  wire                            result_valid,
    input  wire                            result_ready,
    input  rgbe_pkg::result_beat_t         result,
    input  wire                            cfg_valid,
    input  wire                            cfg_ready,
    input  wire [rgbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [rgbe_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             outstanding
);
    import rgbe_pkg::*;

    rgb_t                 line_recent [MAX_WIDTH];
    rgb_t                 line_older  [MAX_WIDTH];
    logic [THR_W-1:0]     thr_halves;
    logic [DIM_CFG_W-1:0] width_reg;
    logic [DIM_CFG_W-1:0] height_reg;
    int                   col_pos;
    int                   row_pos;
    int                   errors;
    result_beat_t         expected_edges [$];

    function automatic int held_dim(input logic [DIM_CFG_W-1:0] v, input int hi);
        if (int'(v) < MIN_DIM)
            return MIN_DIM;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    // any channel whose doubled absolute difference is above the threshold
    function automatic logic gradient_over(input rgb_t a, input rgb_t b,
                                           input logic [THR_W-1:0] thr);
        int d;
        for (int i = 0; i < 3; i++)
        begin
            d = int'(a[CHAN_W*i +: CHAN_W]) - int'(b[CHAN_W*i +: CHAN_W]);
            if (d < 0)
                d = -d;
            if (2 * d > int'(thr))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict
        int           w;
        int           h;
        int           x;
        int           y;
        int           center_row;
        rgb_t         pix;
        result_beat_t want;
        if (!rst_n)
        begin
            thr_halves = THRESHOLD_RESET;
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
            expected_edges.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // results first: a pixel taken at this edge cannot have produced one yet
            if (result_valid && result_ready)
            begin
                if (expected_edges.size() == 0)
                begin
                    $display("%0t: result beat with none expected: edge=%0b col=%0d row=%0d",
                             $time, result.edge_res, result.out_col, result.out_row);
                    errors++;
                end
                else
                begin
                    want = expected_edges.pop_front();
                    if (result.edge_res !== want.edge_res || result.out_col !== want.out_col
                        || result.out_row !== want.out_row)
                    begin
                        $display({"%0t: result mismatch: expected edge=%0b col=%0d row=%0d,",
                                  " got edge=%0b col=%0d row=%0d"},
                                 $time, want.edge_res, want.out_col, want.out_row,
                                 result.edge_res, result.out_col, result.out_row);
                        errors++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THRESHOLD: thr_halves = cfg_data[THR_W-1:0];
                    REG_WIDTH:     width_reg  = cfg_data;
                    REG_HEIGHT:    height_reg = cfg_data;
                    default:       ; // spare index, no register behind it
                endcase
            end

            if (pixel_valid && pixel_ready)
            begin
                w = held_dim(width_reg, MAX_WIDTH);
                h = held_dim(height_reg, MAX_HEIGHT);
                pix.red   = pixel.red;
                pix.green = pixel.green;
                pix.blue  = pixel.blue;
                if (pixel.frame_start)
                begin
                    col_pos = 0;
                    row_pos = 0;
                end
                x = col_pos;
                y = row_pos;

                // center is (x, y-1): line_older[x-1] was already moved down this row
                if (x >= 1 && x + 2 <= w && y >= 2 && y + 1 <= h)
                begin
                    center_row    = y - 1;
                    want.edge_res = gradient_over(line_recent[x+1], line_older[x-1], thr_halves)
                                 || gradient_over(pix, line_older[x], thr_halves);
                    want.out_col  = x[COORD_W-1:0];
                    want.out_row  = center_row[COORD_W-1:0];
                    expected_edges.push_back(want);
                end

                if (x < MAX_WIDTH)
                begin
                    line_older[x]  = line_recent[x];
                    line_recent[x] = pix;
                end

                col_pos = x + 1;
                if (col_pos >= w)
                begin
                    col_pos = 0;
                    row_pos = y + 1;
                    if (row_pos >= h)
                        row_pos = 0;
                end
            end

            fail_count  <= errors;
            outstanding <= expected_edges.size();
        end
    end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives pixel frames and register writes into the RGB edge detector under
// bursty input and a stalling result side; the checker beside the block
// predicts every edge verdict and counts disagreements.
// ----------------------------------------------------------------------------
module tb;

    import rgbe_pkg::*;

    localparam int MAX_DIM       = 1024;
    localparam int RANDOM_PIXELS = 300;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;

    // index 3 decodes to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_e;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  pixel_valid  = 1'b0;
    logic                  pixel_ready;
    pixel_beat_t           pixel        = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_beat_t          result;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int   fail_count;
    int   outstanding;
    int   cycles      = 0;
    int   burst_left  = 0;
    int   cur_w       = int'(DIM_RESET);
    int   cur_h       = int'(DIM_RESET);
    logic hold_req    = 1'b0;

    always #1 clk = ~clk;

    rgb_gradient_edge_threshold #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    edge_result_checker #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: changing stall patterns plus one long hold-off on request
    initial
    begin : receiver
        rx_mode_e mode;
        int       left;
        bit       held;
        mode = RX_OPEN;
        left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (left == 0)
            begin
                mode = rx_mode_e'($urandom_range(0, 3));
                left = $urandom_range(8, 80);
            end
            left--;
            case (mode)
                RX_OPEN:   result_ready <= 1'b1;
                RX_MOSTLY: result_ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                default:   result_ready <= left[1];
            endcase
        end
    end

    function automatic int usable_dim(input logic [CFG_DATA_W-1:0] v);
        if (int'(v) < MIN_DIM)
            return MIN_DIM;
        if (int'(v) > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // mostly small steps around a base color, sometimes a rail value
    function automatic pixel_beat_t random_pixel(input rgb_t base, input int span);
        rgb_t        c;
        pixel_beat_t p;
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                c[CHAN_W*i +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                c[CHAN_W*i +: CHAN_W] = base[CHAN_W*i +: CHAN_W]
                                      + CHAN_W'($urandom_range(0, span));
        end
        p.red         = c.red;
        p.green       = c.green;
        p.blue        = c.blue;
        p.frame_start = 1'b0;
        return p;
    endfunction

    task automatic send_pixel(input pixel_beat_t p);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                pixel_valid <= 1'b0;
                @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 24);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_rgb(input int r, input int g, input int b, input bit fs);
        pixel_beat_t p;
        p.red         = r[CHAN_W-1:0];
        p.green       = g[CHAN_W-1:0];
        p.blue        = b[CHAN_W-1:0];
        p.frame_start = fs;
        send_pixel(p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // drain every expected result, then give pixels with no result time to clear
    task automatic settle();
        pixel_valid <= 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] thr_data,
                             input logic [CFG_DATA_W-1:0] w_raw,
                             input logic [CFG_DATA_W-1:0] h_raw,
                             input logic [3:0] regs_to_write,
                             input int rows, input int extra,
                             input bit noisy, input int hold_at,
                             output int count);
        int          new_w;
        int          new_h;
        bit          restart;
        rgb_t        base;
        int          span;
        pixel_beat_t p;
        settle();
        new_w = cur_w;
        new_h = cur_h;
        if ($urandom_range(0, 9) == 0)
            write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 2047)));
        if (regs_to_write[REG_THRESHOLD])
            write_reg(REG_THRESHOLD, thr_data);
        if (regs_to_write[REG_WIDTH])
        begin
            write_reg(REG_WIDTH, w_raw);
            new_w = usable_dim(w_raw);
        end
        if (regs_to_write[REG_HEIGHT])
        begin
            write_reg(REG_HEIGHT, h_raw);
            new_h = usable_dim(h_raw);
        end
        // a grown geometry must start a fresh frame so no stale line entry is read
        restart = (new_w > cur_w) || (new_h > cur_h) || ($urandom_range(0, 1) == 1);
        cur_w = new_w;
        cur_h = new_h;

        base  = 24'($urandom_range(0, 24'hFFFFFF));
        span  = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 30);
        count = cur_w * rows + (extra % cur_w);
        for (int i = 0; i < count; i++)
        begin
            p = random_pixel(base, span);
            p.frame_start = (i == 0 && restart) || (noisy && $urandom_range(0, 199) == 0);
            if (i == hold_at)
                hold_req <= 1'b1;
            send_pixel(p);
        end
    endtask

    initial
    begin : stimulus
        int                    random_sent;
        int                    phase_no;
        int                    n;
        int                    pick;
        logic [THR_W-1:0]      thr;
        logic [1:0]            thr_hi;
        logic [CFG_DATA_W-1:0] w_raw;
        logic [CFG_DATA_W-1:0] h_raw;
        random_sent = 0;
        phase_no    = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frames, widths below the minimum get held at three
        write_reg(REG_SPARE, 11'h7FF);
        write_reg(REG_WIDTH, 11'd0);
        write_reg(REG_HEIGHT, 11'd1);
        cur_w = usable_dim(11'd0);
        cur_h = usable_dim(11'd1);

        // reset threshold, differences of exactly ten: not an edge
        send_rgb(0, 0, 0, 1'b1);
        send_rgb(200, 50, 0, 1'b0);
        send_rgb(255, 255, 255, 1'b0);
        send_rgb(100, 100, 100, 1'b0);
        send_rgb(7, 7, 7, 1'b0);
        send_rgb(110, 100, 100, 1'b0);
        send_rgb(9, 9, 9, 1'b0);
        send_rgb(200, 50, 10, 1'b0);
        send_rgb(1, 2, 3, 1'b0);

        // new frame by counter wrap alone; green differs by eleven: edge
        send_rgb(0, 0, 0, 1'b0);
        send_rgb(255, 255, 255, 1'b0);
        send_rgb(0, 0, 0, 1'b0);
        send_rgb(60, 60, 60, 1'b0);
        send_rgb(128, 128, 128, 1'b0);
        send_rgb(60, 71, 60, 1'b0);
        send_rgb(0, 0, 0, 1'b0);
        send_rgb(255, 255, 255, 1'b0);
        send_rgb(255, 255, 255, 1'b0);

        // threshold above any possible difference, full-scale steps
        settle();
        write_reg(REG_THRESHOLD, 11'h1FF);
        send_rgb(0, 0, 0, 1'b1);
        send_rgb(0, 0, 0, 1'b0);
        send_rgb(255, 255, 255, 1'b0);
        send_rgb(255, 255, 255, 1'b0);
        send_rgb(128, 128, 128, 1'b0);
        send_rgb(0, 0, 0, 1'b0);
        send_rgb(0, 0, 0, 1'b0);
        send_rgb(255, 255, 255, 1'b0);

        // oversized geometry held at the maximum: two full lines and part of a third
        run_phase(11'h628, 11'h7FF, 11'h7FF, 4'b0111, 2, 40, 1'b0, -1, n);

        while (random_sent < RANDOM_PIXELS)
        begin
            case (phase_no)
                0:       thr = 9'd0;
                1:       thr = 9'd510;
                2:       thr = 9'd511;
                default: thr = THR_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 511)
                                                                  : $urandom_range(0, 60));
            endcase
            thr_hi = 2'($urandom_range(0, 3));

            if (phase_no == 0)
            begin
                // long result hold-off while the sender keeps offering pixels
                run_phase({thr_hi, thr}, 11'd8, 11'd40, 4'b0111, 6, 3, 1'b1, 20, n);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    w_raw = CFG_DATA_W'($urandom_range(3, 24));
                else if (pick < 85)
                    w_raw = CFG_DATA_W'($urandom_range(25, 120));
                else
                    w_raw = CFG_DATA_W'($urandom_range(0, 2));
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    h_raw = CFG_DATA_W'($urandom_range(3, 12));
                else if (pick < 85)
                    h_raw = CFG_DATA_W'($urandom_range(0, 2));
                else
                    h_raw = CFG_DATA_W'($urandom_range(13, 2047));
                run_phase({thr_hi, thr}, w_raw, h_raw,
                          (phase_no < 3) ? 4'b0111 : 4'($urandom_range(0, 7)),
                          $urandom_range(2, 7), $urandom_range(0, 40), 1'b1, -1, n);
            end
            random_sent += n;
            phase_no++;
        end

        settle();
        if (fail_count == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
